FILE: hw/rtl/nmea_rx_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence receiver.
// No dependencies; used by nmea_sentence_receiver.
`default_nettype none

package nmea_rx_pkg;

    localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_ASTERISK = 8'h2A;
    localparam logic [7:0] CHAR_NUL      = 8'h00;
    localparam logic [7:0] MAX_LEN_RESET = 8'd100;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_BODY   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_TAIL   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_MALFORM  = 2'd2,
        ST_OVERLEN  = 2'd3
    } status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit, upper or lower case.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.ok    = 1'b1;
            h.value = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.ok    = 1'b1;
            h.value = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nmea_sentence_receiver.sv
// NMEA 0183 sentence receiver: framing, XOR checksum check and status.
// Depends on nmea_rx_pkg.
`default_nettype none

// Takes one received byte per transfer on the s_ channel and passes every
// sentence byte, from '$' through the closing newline, out on the m_ channel.
// A '$' always opens a new sentence (m_tuser first bit set); any sentence in
// progress is dropped. Bytes outside a sentence give no output transfer.
// Characters between '$' and '*' are XOR-folded; hex digits after '*' form
// the transmitted checksum, ended by the first non-hex byte. The byte that
// ends a sentence carries m_tlast and a status in m_tuser: 0 good,
// 1 checksum mismatch (or more than two significant digits), 2 malformed
// (no '*' before the newline, or a zero byte inside the sentence),
// 3 overlength. A sentence is abandoned with overlength on the first
// non-'$' byte that arrives once max_length bytes have been taken; that
// byte is passed with m_tlast. max_length is written through cfg_we and
// cfg_wdata and must only change while the block is idle.
// Timing: one byte per clock sustained while m_tready holds. A byte lands in an input
// register, the framing logic on it is combinational and the result goes to an output
// register, so each byte passes the input register and then the output register
// before m_tvalid shows it.
// Both registers advance together whenever the output register is empty or
// being drained, so back-to-back bytes flow with no bubbles.
module nmea_sentence_receiver (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,     // max_length
    // received bytes
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] rx_byte
    // sentence bytes
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [7:0] out_byte
    output logic            m_tlast,       // last
    output logic [2:0]      m_tuser        // [0] first, [2:1] status
);

    // configuration register
    logic [7:0] max_len_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // sentence state
    nmea_rx_pkg::phase_t phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] sum_reg, sum_next;
    logic       too_big_reg, too_big_next;
    logic       malformed_reg, malformed_next;
    logic [7:0] count_reg, count_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_first_reg;
    logic       out_last_reg;
    nmea_rx_pkg::status_t out_status_reg;

    // result of the current byte
    logic       res_valid;
    logic       res_first;
    logic       res_last;
    nmea_rx_pkg::status_t res_status;

    logic advance;
    logic is_dollar;
    logic is_newline;
    logic over_len;
    nmea_rx_pkg::hex_digit_t digit;

    // Both stages move together when the output register can take a result.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    assign is_dollar  = (in_byte_reg == nmea_rx_pkg::CHAR_DOLLAR);
    assign is_newline = (in_byte_reg == nmea_rx_pkg::CHAR_NEWLINE);
    assign over_len   = (count_reg >= max_len_reg);
    assign digit      = nmea_rx_pkg::hex_decode(in_byte_reg);

    // Next sentence state.
    always_comb begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        sum_next       = sum_reg;
        too_big_next   = too_big_reg;
        malformed_next = malformed_reg;
        count_next     = count_reg;
        if (is_dollar) begin
            phase_next     = nmea_rx_pkg::PH_BODY;
            xor_next       = 8'd0;
            sum_next       = 8'd0;
            too_big_next   = 1'b0;
            malformed_next = 1'b0;
            count_next     = 8'd1;
        end else if (phase_reg != nmea_rx_pkg::PH_HUNT) begin
            if (over_len) begin
                phase_next = nmea_rx_pkg::PH_HUNT;
            end else begin
                count_next = count_reg + 8'd1;
                if (in_byte_reg == nmea_rx_pkg::CHAR_NUL) begin
                    malformed_next = 1'b1;
                end
                if (is_newline) begin
                    phase_next = nmea_rx_pkg::PH_HUNT;
                end else begin
                    case (phase_reg)
                        nmea_rx_pkg::PH_BODY: begin
                            if (in_byte_reg == nmea_rx_pkg::CHAR_ASTERISK) begin
                                phase_next = nmea_rx_pkg::PH_DIGITS;
                            end else begin
                                xor_next = xor_reg ^ in_byte_reg;
                            end
                        end
                        nmea_rx_pkg::PH_DIGITS: begin
                            if (digit.ok) begin
                                if (sum_reg[7:4] != 4'd0) begin
                                    too_big_next = 1'b1;
                                end
                                sum_next = {sum_reg[3:0], digit.value};
                            end else begin
                                phase_next = nmea_rx_pkg::PH_TAIL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // Result of the current byte.
    always_comb begin
        res_valid  = 1'b0;
        res_first  = 1'b0;
        res_last   = 1'b0;
        res_status = nmea_rx_pkg::ST_GOOD;
        if (is_dollar) begin
            res_valid = 1'b1;
            res_first = 1'b1;
        end else if (phase_reg != nmea_rx_pkg::PH_HUNT) begin
            res_valid = 1'b1;
            if (over_len) begin
                res_last   = 1'b1;
                res_status = nmea_rx_pkg::ST_OVERLEN;
            end else if (is_newline) begin
                res_last = 1'b1;
                if (malformed_reg || in_byte_reg == nmea_rx_pkg::CHAR_NUL
                        || phase_reg == nmea_rx_pkg::PH_BODY) begin
                    res_status = nmea_rx_pkg::ST_MALFORM;
                end else if (too_big_reg || xor_reg != sum_reg) begin
                    res_status = nmea_rx_pkg::ST_MISMATCH;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= nmea_rx_pkg::MAX_LEN_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    // Hold the input byte and advance it together with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
        if (advance && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= nmea_rx_pkg::PH_HUNT;
            xor_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            too_big_reg   <= 1'b0;
            malformed_reg <= 1'b0;
            count_reg     <= 8'd0;
        end else if (advance && in_valid_reg) begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            sum_reg       <= sum_next;
            too_big_reg   <= too_big_next;
            malformed_reg <= malformed_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && res_valid;
        end
        if (advance && in_valid_reg && res_valid) begin
            out_byte_reg   <= in_byte_reg;
            out_first_reg  <= res_first;
            out_last_reg   <= res_last;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_status_reg, out_first_reg};

    // A sentence start is always the dollar byte itself.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == nmea_rx_pkg::CHAR_DOLLAR && !m_tlast))
        else $error("first mark on a byte other than dollar");

    // Status is zero on every byte that does not end a sentence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == nmea_rx_pkg::ST_GOOD))
        else $error("nonzero status without last");

    // A sentence that ends without overlength ends on a newline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && m_tuser[2:1] != nmea_rx_pkg::ST_OVERLEN)
            |-> (m_tdata == nmea_rx_pkg::CHAR_NEWLINE))
        else $error("sentence closed on a byte other than newline");

    // Once a sentence closes, the framer is back to hunting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && res_last) |=> (phase_reg == nmea_rx_pkg::PH_HUNT))
        else $error("framer did not return to hunting after last byte");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for nmea_sentence_receiver: sentence framing, XOR checksum status.
// A byte-level framer model predicts every output transfer, and the checker compares them.
// Depends on nmea_rx_pkg and nmea_sentence_receiver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Two-stage pipeline inside the block; allow a little slack past it.
    localparam int         DRAIN_CYCLES    = 4;
    localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

    // One expected output transfer.
    typedef struct packed {
        logic [7:0]           data;
        logic                 first;
        logic                 last;
        nmea_rx_pkg::status_t status;
    } sentence_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [7:0] out_byte
    logic       m_tlast;
    logic [2:0] m_tuser;     // [0] first, [2:1] status

    // Framer model state, mirrors the block's registers.
    nmea_rx_pkg::phase_t frame_phase;
    logic [7:0] xor_fold;
    logic [7:0] sent_sum;
    logic       sum_overflow;
    logic       saw_nul;
    logic [7:0] sentence_len;
    logic [7:0] length_limit;

    sentence_beat_t expected_beats[$];
    int             bytes_sent;
    int             mismatch_count;
    bit             steady_flow;     // when set, neither side inserts idle cycles

    nmea_sentence_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Framer model
    // ------------------------------------------------------------------

    // Value of an ASCII hex digit, or -1 for anything else.
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    // Advance the model by one accepted byte and queue the transfer it causes.
    task automatic predict_sentence_byte(input logic [7:0] b);
        sentence_beat_t beat;
        int             nib;
        beat.data   = b;
        beat.first  = 1'b0;
        beat.last   = 1'b0;
        beat.status = nmea_rx_pkg::ST_GOOD;
        if (b == nmea_rx_pkg::CHAR_DOLLAR) begin
            // A dollar always opens a fresh sentence, whatever came before.
            frame_phase  = nmea_rx_pkg::PH_BODY;
            xor_fold     = 8'd0;
            sent_sum     = 8'd0;
            sum_overflow = 1'b0;
            saw_nul      = 1'b0;
            sentence_len = 8'd1;
            beat.first   = 1'b1;
        end else if (frame_phase == nmea_rx_pkg::PH_HUNT) begin
            return;     // dropped while hunting
        end else if (sentence_len >= length_limit) begin
            // Abandon: this byte closes the sentence with overlength.
            frame_phase = nmea_rx_pkg::PH_HUNT;
            beat.last   = 1'b1;
            beat.status = nmea_rx_pkg::ST_OVERLEN;
        end else begin
            sentence_len = sentence_len + 8'd1;
            if (b == nmea_rx_pkg::CHAR_NUL)
                saw_nul = 1'b1;
            if (b == nmea_rx_pkg::CHAR_NEWLINE) begin
                beat.last = 1'b1;
                if (saw_nul || frame_phase == nmea_rx_pkg::PH_BODY)
                    beat.status = nmea_rx_pkg::ST_MALFORM;
                else if (sum_overflow || xor_fold != sent_sum)
                    beat.status = nmea_rx_pkg::ST_MISMATCH;
                frame_phase = nmea_rx_pkg::PH_HUNT;
            end else if (frame_phase == nmea_rx_pkg::PH_BODY) begin
                if (b == nmea_rx_pkg::CHAR_ASTERISK)
                    frame_phase = nmea_rx_pkg::PH_DIGITS;
                else
                    xor_fold = xor_fold ^ b;
            end else if (frame_phase == nmea_rx_pkg::PH_DIGITS) begin
                nib = hex_nibble(b);
                if (nib >= 0) begin
                    // A third significant digit pushes the value past one byte.
                    if (sent_sum >= 8'd16)
                        sum_overflow = 1'b1;
                    sent_sum = {sent_sum[3:0], 4'(nib)};
                end else begin
                    frame_phase = nmea_rx_pkg::PH_TAIL;
                end
            end
        end
        expected_beats.push_back(beat);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : result_check
        sentence_beat_t beat;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer data=%02h last=%0b user=%03b",
                                          m_tdata, m_tlast, m_tuser));
            end else begin
                beat = expected_beats.pop_front();
                if (m_tdata !== beat.data || m_tuser[0] !== beat.first ||
                    m_tlast !== beat.last || m_tuser[2:1] !== beat.status) begin
                    report_mismatch($sformatf(
                        "data %02h/%02h first %b/%b last %b/%b status %0d/%0d (got/exp)",
                        m_tdata, beat.data, m_tuser[0], beat.first,
                        m_tlast, beat.last, m_tuser[2:1], beat.status));
                end
            end
        end
    end

    // Result side: after each transfer, optionally hold off for a while.
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                stall = steady_flow ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one byte after a random gap; hold it until the transfer happens.
    // tvalid stays high on a zero gap so back-to-back bytes are not split.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_sentence_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
    endtask

    // Stop sending and let every outstanding transfer come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only change the limit with the pipeline empty.
    task automatic write_max_length(input logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        length_limit  = value;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    // Build and send one sentence. Most come out well formed with a random body;
    // the rest carry a flaw so every status shows up.
    task automatic send_random_sentence();
        logic [7:0] line[$];
        logic [7:0] sum;
        logic [7:0] b;
        int         flaw;
        int         body_len;
        int         nul_pos;
        int         digits;
        flaw     = $urandom_range(0, 9);  // 0..5 clean, 6 no asterisk, 7 nul,
                                          // 8 digit count of 0..4, 9 raw bytes
        body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 110)
                                               : $urandom_range(0, 12);
        nul_pos  = $urandom_range(0, body_len);
        sum      = 8'd0;
        line.push_back(nmea_rx_pkg::CHAR_DOLLAR);
        if (flaw == 9) begin
            repeat ($urandom_range(1, 12)) line.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i <= body_len; i++) begin
                if (flaw == 7 && i == nul_pos)
                    line.push_back(nmea_rx_pkg::CHAR_NUL);
                if (i < body_len) begin
                    do b = 8'($urandom_range(8'h20, 8'h7E));
                    while (b == nmea_rx_pkg::CHAR_DOLLAR || b == nmea_rx_pkg::CHAR_ASTERISK);
                    line.push_back(b);
                    sum ^= b;
                end
            end
            if (flaw != 6) begin
                line.push_back(nmea_rx_pkg::CHAR_ASTERISK);
                // Corrupt the transmitted value now and then.
                if ($urandom_range(0, 5) == 0)
                    sum ^= 8'($urandom_range(1, 255));
                digits = (flaw == 8) ? $urandom_range(0, 4) : 2;
                if (digits == 2) begin
                    line.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
                    line.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
                end else begin
                    repeat (digits)
                        line.push_back(hex_char(4'($urandom_range(0, 15)),
                                                1'($urandom_range(0, 1))));
                end
                if ($urandom_range(0, 1))
                    line.push_back(CARRIAGE_RETURN);
            end
            line.push_back(nmea_rx_pkg::CHAR_NEWLINE);
        end
        foreach (line[i])
            send_byte(line[i]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes outside a sentence, including both byte extremes, must vanish;
    // then the shortest good sentence, with no checksum digits at all.
    task automatic test_hunting();
        send_byte(8'hFF);
        send_byte(nmea_rx_pkg::CHAR_NUL);
        send_byte(nmea_rx_pkg::CHAR_NEWLINE);
        send_byte(nmea_rx_pkg::CHAR_ASTERISK);
        send_text("$*\n");
    endtask

    // Restart on a second dollar, lower case digits, and a value over one byte.
    task automatic test_checksum();
        send_text("$A$j*6a\n");
        send_text("$*1F0\n");
    endtask

    // Newline before any asterisk, and a zero byte inside a sentence.
    task automatic test_malformed();
        send_text("$A\n");
        send_byte(nmea_rx_pkg::CHAR_DOLLAR);
        send_byte(nmea_rx_pkg::CHAR_NUL);
        send_text("*\n");
    endtask

    // Abandon at small limits, including zero; a dollar at the limit still restarts.
    task automatic test_overlength();
        write_max_length(8'd3);
        send_text("$AB");
        send_byte(8'hFF);
        send_text("$AB$");
        write_max_length(8'd0);
        send_text("$A");
    endtask

    // Random sentences under one limit, until enough bytes have been sent.
    task automatic test_random_traffic(input logic [7:0] limit, input int target);
        int start;
        write_max_length(limit);
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
                send_random_sentence();
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            // Hold off now and then until the output side has caught up.
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
        steady_flow = 1'b0;
    endtask

    initial begin : test_sequence
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= 8'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'd0;
        steady_flow  = 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        frame_phase  = nmea_rx_pkg::PH_HUNT;
        xor_fold     = 8'd0;
        sent_sum     = 8'd0;
        sum_overflow = 1'b0;
        saw_nul      = 1'b0;
        sentence_len = 8'd0;
        length_limit = nmea_rx_pkg::MAX_LEN_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_hunting();
        test_checksum();
        test_malformed();
        test_overlength();

        test_random_traffic(nmea_rx_pkg::MAX_LEN_RESET, 110);
        test_random_traffic(8'd255, 60);
        test_random_traffic(8'($urandom_range(3, 40)), 60);
        test_random_traffic(8'd3, 40);
        test_random_traffic(8'($urandom_range(0, 2)), 40);
        test_random_traffic(8'd16, 60);

        wait_drained();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
